// ===== rtl/sgrr_pkg.sv =====
// package for the scaled glyph rectangle rasteriser
// types, font table and constants shared by front, queue, back end and checker
// no dependencies
package sgrr_pkg;

  localparam int GLYPH_ROWS  = 7;
  localparam int GLYPH_COLS  = 5;
  localparam int GLYPH_BITS  = GLYPH_ROWS * GLYPH_COLS;
  localparam int QUEUE_DEPTH = 2;
  localparam int FONT_LETTERS = 26;

  localparam logic [11:0] SCREEN_WIDTH_RESET  = 12'd1024;
  localparam logic [11:0] SCREEN_HEIGHT_RESET = 12'd768;

  localparam logic [7:0] CODE_SPACE = 8'h20;
  localparam logic [7:0] CODE_FIRST = 8'h41;
  localparam logic [7:0] CODE_LAST  = 8'h5A;

  typedef enum logic [0:0] {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef logic [GLYPH_BITS-1:0] glyph_t;

  typedef struct packed {
    logic        start_of_string;
    logic [11:0] start_x;
    logic [11:0] base_y;
    logic [7:0]  char_code;
    logic [23:0] fill_color;
    logic [4:0]  scale;
  } in_item_t;

  typedef struct packed {
    logic [11:0] rect_x;
    logic [11:0] rect_y;
    logic [4:0]  rect_w;
    logic [4:0]  rect_h;
    logic [23:0] rect_color;
    logic        last_of_char;
  } rect_t;

  // one character handed from the front to the back end
  typedef struct packed {
    logic [15:0] pen;
    logic [11:0] base_y;
    logic [23:0] color;
    logic [4:0]  scale;
    glyph_t      glyph;
  } cmd_t;

  typedef struct packed {
    logic [11:0] width;
    logic [11:0] height;
  } screen_t;

  // rows top to bottom, leftmost column in the msb of each row
  localparam glyph_t FONT [FONT_LETTERS] = '{
    {5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17}, // A
    {5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30}, // B
    {5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14}, // C
    {5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30}, // D
    {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31}, // E
    {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16}, // F
    {5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd15}, // G
    {5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17}, // H
    {5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd31}, // I
    {5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0 }, // J
    {5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0 }, // K
    {5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31}, // L
    {5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17}, // M
    {5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17}, // N
    {5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14}, // O
    {5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16}, // P
    {5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0 }, // Q
    {5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17}, // R
    {5'd15, 5'd16, 5'd16, 5'd14, 5'd1,  5'd1,  5'd30}, // S
    {5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4 }, // T
    {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14}, // U
    {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4 }, // V
    {5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0 }, // W
    {5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0 }, // X
    {5'd17, 5'd17, 5'd10, 5'd4,  5'd4,  5'd4,  5'd4 }, // Y
    {5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0 }  // Z
  };

  function automatic glyph_t glyph_lookup(input logic [7:0] code);
    logic [7:0] offset;
    offset = code - CODE_FIRST;
    if (code < CODE_FIRST || code > CODE_LAST) begin
      return '0;
    end
    return FONT[offset[4:0]];
  endfunction

endpackage

// ===== rtl/sgrr_front.sv =====
// front end: accepts characters, tracks the pen and classifies each character
// forwards characters with dots to the queue; uses sgrr_pkg
module sgrr_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  sgrr_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              push,
  output sgrr_pkg::cmd_t    cmd
);
  import sgrr_pkg::*;

  logic [15:0] pen_x;
  logic [15:0] pen_x_next;
  logic [15:0] pen_cur;
  logic [7:0]  advance;
  logic [16:0] pen_sum;
  logic        is_space;
  glyph_t      glyph;
  logic        accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  assign pen_cur  = in_data.start_of_string ? {4'd0, in_data.start_x} : pen_x;
  assign is_space = (in_data.char_code == CODE_SPACE);
  assign glyph    = glyph_lookup(in_data.char_code);

  // 4 or 6 times the scale
  always_comb begin
    if (is_space) begin
      advance = {1'b0, in_data.scale, 2'b00};
    end else begin
      advance = {1'b0, in_data.scale, 2'b00} + {2'b00, in_data.scale, 1'b0};
    end
  end

  assign pen_sum    = {1'b0, pen_cur} + {9'd0, advance};
  assign pen_x_next = pen_sum[16] ? 16'hFFFF : pen_sum[15:0];

  // only letters with dots and a non-zero scale need the back end
  assign push = accept && !is_space && (in_data.scale != 5'd0) && (glyph != '0);

  assign cmd.pen    = pen_cur;
  assign cmd.base_y = in_data.base_y;
  assign cmd.color  = in_data.fill_color;
  assign cmd.scale  = in_data.scale;
  assign cmd.glyph  = glyph;

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x <= '0;
    end else if (accept) begin
      pen_x <= pen_x_next;
    end
  end

endmodule

// ===== rtl/sgrr_queue.sv =====
// short command queue between front and back end
// holds DEPTH characters; uses sgrr_pkg
module sgrr_queue #(
  parameter int DEPTH = sgrr_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sgrr_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output sgrr_pkg::cmd_t head
);
  import sgrr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign valid   = (count != '0);
  assign head    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/sgrr_back.sv =====
// back end: scans the glyph one dot a cycle unless the output stalls, clips and emits rectangles
// one rectangle is held back so the last one of a character can be marked; uses sgrr_pkg
module sgrr_back (
  input  logic              clk,
  input  logic              rst,
  input  sgrr_pkg::screen_t screen,
  input  logic              q_valid,
  input  sgrr_pkg::cmd_t    q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output sgrr_pkg::rect_t   out_data
);
  import sgrr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t      state;
  glyph_t      shift;
  logic [16:0] x_acc;
  logic [12:0] y_acc;
  logic [2:0]  col;
  logic [15:0] pen;
  logic [4:0]  scale;
  logic [23:0] color;
  logic        pend_valid;
  rect_t       pend;

  logic        in_x;
  logic        in_y;
  logic        cand;
  logic [17:0] x_end;
  logic [13:0] y_end;
  logic [11:0] w_room;
  logic [11:0] h_room;
  logic [4:0]  cand_w;
  logic [4:0]  cand_h;
  logic        out_free;
  logic        step;
  logic        load_mid;
  logic        load_last;

  assign in_x = x_acc < {5'd0, screen.width};
  assign in_y = y_acc < {1'b0, screen.height};
  assign cand = (state == ST_SCAN) && shift[GLYPH_BITS-1] && in_x && in_y;

  // clip against the right and bottom edges
  assign x_end  = {1'b0, x_acc} + {13'd0, scale};
  assign y_end  = {1'b0, y_acc} + {9'd0, scale};
  assign w_room = screen.width - x_acc[11:0];
  assign h_room = screen.height - y_acc[11:0];
  assign cand_w = (x_end > {6'd0, screen.width})  ? w_room[4:0] : scale;
  assign cand_h = (y_end > {2'd0, screen.height}) ? h_room[4:0] : scale;

  assign out_free  = !out_valid || !out_stall;
  assign step      = (state == ST_SCAN) && !(cand && pend_valid && !out_free);
  assign load_mid  = step && cand && pend_valid;
  assign load_last = (state == ST_FLUSH) && pend_valid && out_free;
  assign q_pop     = (state == ST_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (step && (shift[GLYPH_BITS-2:0] == '0)) begin
            state <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (!pend_valid || out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (step && cand) begin
        pend_valid <= 1'b1;
      end else if (load_last) begin
        pend_valid <= 1'b0;
      end
      if (load_mid || load_last) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (q_pop) begin
      shift <= q_head.glyph;
      pen   <= q_head.pen;
      scale <= q_head.scale;
      color <= q_head.color;
      x_acc <= {1'b0, q_head.pen};
      y_acc <= {1'b0, q_head.base_y};
      col   <= '0;
    end else if (step) begin
      shift <= shift << 1;
      if (col == 3'(GLYPH_COLS - 1)) begin
        col   <= '0;
        x_acc <= {1'b0, pen};
        y_acc <= y_acc + {8'd0, scale};
      end else begin
        col   <= col + 3'd1;
        x_acc <= x_acc + {12'd0, scale};
      end
    end
    if (step && cand) begin
      pend.rect_x       <= x_acc[11:0];
      pend.rect_y       <= y_acc[11:0];
      pend.rect_w       <= cand_w;
      pend.rect_h       <= cand_h;
      pend.rect_color   <= color;
      pend.last_of_char <= 1'b0;
    end
    // the held-back rectangle is the last one once the scan is over
    if (load_mid || load_last) begin
      out_data <= {pend.rect_x, pend.rect_y, pend.rect_w, pend.rect_h, pend.rect_color,
                   load_last};
    end
  end

endmodule

// ===== rtl/scaled_glyph_rect_rasterizer.sv =====
// top level of the scaled glyph rectangle rasteriser
// instantiates sgrr_front, sgrr_queue and sgrr_back; uses sgrr_pkg
//
// Draws one character per input beat from a built-in 5x7 font of twenty capitals
// as one fill rectangle (scale by scale pixels) per set dot, scanning rows from the
// top and each row from the left. Rectangles whose origin is off screen are dropped,
// the others are clipped to the screen width and height; last_of_char marks the
// final rectangle of a character. start_of_string loads the pen from start_x, after
// which the pen advances by 6*scale (4*scale for a space) and saturates at 65535.
// Spaces, unknown codes, blank glyphs and scale zero are accepted at the input and
// produce nothing. A drawable character is popped from the queue, scanned one dot
// position at a time up to its last set dot (at most 35 positions), and then its
// held-back rectangle is released.
// The front end and the back end are parted by a short queue, so characters keep
// being accepted while earlier ones are drawn; an output register holds each beat.
// screen_width and screen_height are written through cfg_we/cfg_index/cfg_data and
// must only change while no character is in flight.
module scaled_glyph_rect_rasterizer #(
  parameter int QUEUE_DEPTH = sgrr_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  // character input
  input  logic               in_valid,
  output logic               in_stall,
  input  sgrr_pkg::in_item_t in_data,
  // rectangle output
  output logic               out_valid,
  input  logic               out_stall,
  output sgrr_pkg::rect_t    out_data,
  // configuration writes
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [11:0]        cfg_data
);
  import sgrr_pkg::*;

  screen_t screen;
  logic    q_full;
  logic    q_push;
  cmd_t    q_push_data;
  logic    q_valid;
  logic    q_pop;
  cmd_t    q_head;

  // screen limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      screen.width  <= SCREEN_WIDTH_RESET;
      screen.height <= SCREEN_HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SCREEN_WIDTH:  screen.width  <= cfg_data;
        REG_SCREEN_HEIGHT: screen.height <= cfg_data;
        default: begin
          screen <= screen;
        end
      endcase
    end
  end

  // pen tracking and character classification
  sgrr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (q_push),
    .cmd      (q_push_data)
  );

  // decouples input acceptance from drawing
  sgrr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  // dot scan, clipping and output register
  sgrr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .screen    (screen),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/sgrr_checker.sv =====
// port-level checks for the scaled glyph rectangle rasteriser
// bound to scaled_glyph_rect_rasterizer; uses sgrr_pkg
module sgrr_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input sgrr_pkg::rect_t    out_data
);
  import sgrr_pkg::*;

  // a stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

  // nothing in flight straight after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !in_stall)
    else $error("block not empty after reset");

  // clipped rectangles are never empty
  a_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.rect_w != 5'd0) && (out_data.rect_h != 5'd0))
    else $error("empty rectangle emitted");

  // clipping keeps every rectangle inside a 12-bit screen
  a_inside: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (({1'b0, out_data.rect_x} + {8'd0, out_data.rect_w}) <= 13'd4095) &&
                  (({1'b0, out_data.rect_y} + {8'd0, out_data.rect_h}) <= 13'd4095))
    else $error("rectangle reaches past the screen");

endmodule

bind scaled_glyph_rect_rasterizer sgrr_checker u_checker (.*);
